// ===== design/sasi_pkg.sv =====
`default_nettype none
package sasi_pkg;

	// Defaults of the top-level parameters
	localparam int unsigned MAX_SEGMENTS_DEF = 4096;
	localparam int unsigned SINE_ITER_DEF    = 24;

	// Field widths
	localparam int unsigned ANGLE_W  = 32;
	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned SUM_W    = 38;
	localparam int unsigned INTEG_W  = 45;
	localparam int unsigned SAMPLE_W = 25;
	localparam int unsigned FRAC_W   = 24;
	localparam int unsigned CORDIC_W = 34;
	localparam int unsigned PROD_W   = 47;

	// Small queue between the front and the sine pipeline
	localparam int unsigned QUEUE_DEPTH = 4;

	// Arithmetic constants
	localparam logic signed [50:0] PI_Q48      = 51'sh3243F6A8885A3;
	localparam logic [50:0]        HALF_PI_Q48 = 51'h1921FB54442D1;
	localparam logic signed [33:0] GAIN_Q30    = 34'sh026DD3B6A;
	localparam logic signed [15:0] RECIP_PI    = 16'sd20860;
	localparam logic [24:0]        ONE_Q24     = 25'h1000000;

	// Simpson weight of a sample
	typedef enum logic [1:0] {WT_ONE, WT_TWO, WT_FOUR} weight_t;

	// What a queue beat stands for
	typedef enum logic [1:0] {KIND_SAMPLE, KIND_REJECT, KIND_EMPTY} kind_t;

	typedef struct packed {
		kind_t   kind;
		weight_t weight;
		logic    last;
	} tag_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		tag_t               tag;
	} entry_t;

	// CORDIC arctangent table, Q.30
	function automatic logic [30:0] atan_q30(input int unsigned idx);
		logic [30:0] v;
		unique case (idx)
			0: v = 31'h3243F6A8;
			1: v = 31'h1DAC6705;
			2: v = 31'h0FADBAFC;
			3: v = 31'h07F56EA6;
			4: v = 31'h03FEAB76;
			5: v = 31'h01FFD55B;
			6: v = 31'h00FFFAAA;
			7: v = 31'h007FFF55;
			8: v = 31'h003FFFEA;
			9: v = 31'h001FFFFD;
			10: v = 31'h000FFFFF;
			11: v = 31'h0007FFFF;
			12: v = 31'h0003FFFF;
			13: v = 31'h0001FFFF;
			14: v = 31'h0000FFFF;
			15: v = 31'h00007FFF;
			16: v = 31'h00003FFF;
			17: v = 31'h00001FFF;
			18: v = 31'h00000FFF;
			19: v = 31'h000007FF;
			20: v = 31'h000003FF;
			21: v = 31'h000001FF;
			22: v = 31'h000000FF;
			23: v = 31'h0000007F;
			24: v = 31'h0000003F;
			25: v = 31'h0000001F;
			26: v = 31'h0000000F;
			27: v = 31'h00000008;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/sasi_front.sv =====
`default_nettype none
module sasi_front #(
	parameter int unsigned MAX_SEGMENTS = sasi_pkg::MAX_SEGMENTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 accept,
	input  wire logic signed [sasi_pkg::ANGLE_W-1:0]  lower_limit,
	input  wire logic signed [sasi_pkg::ANGLE_W-1:0]  step_size,
	input  wire logic        [sasi_pkg::COUNT_W-1:0]  segment_count,
	input  wire logic                                 full,
	output logic                                      push,
	output sasi_pkg::entry_t                          entry,
	output logic signed [sasi_pkg::ANGLE_W-1:0]       step
);

	typedef enum logic [1:0] {FE_IDLE, FE_GEN, FE_ONE} fe_state_t;

	fe_state_t                        state_q;
	logic [sasi_pkg::ANGLE_W-1:0]     angle_q;
	logic [sasi_pkg::COUNT_W-1:0]     idx_q;
	logic [sasi_pkg::COUNT_W-1:0]     n_q;
	logic signed [sasi_pkg::ANGLE_W-1:0] step_q;
	sasi_pkg::kind_t                  kind_q;
	logic                             is_last;
	logic                             bad;

	assign bad = segment_count[0] || (segment_count > sasi_pkg::COUNT_W'(MAX_SEGMENTS));
	assign is_last = (idx_q == n_q);
	assign push = (state_q != FE_IDLE) && !full;
	assign step = step_q;

	// Build the beat for the current sample or the single classification beat
	always_comb begin
		entry.angle = angle_q;
		entry.tag.kind = (state_q == FE_GEN) ? sasi_pkg::KIND_SAMPLE : kind_q;
		entry.tag.last = is_last || (state_q != FE_GEN);
		if (idx_q == '0 || is_last) begin
			entry.tag.weight = sasi_pkg::WT_ONE;
		end else if (idx_q[0]) begin
			entry.tag.weight = sasi_pkg::WT_FOUR;
		end else begin
			entry.tag.weight = sasi_pkg::WT_TWO;
		end
	end

	// Request classification and angle stepping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			angle_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			step_q <= '0;
			kind_q <= sasi_pkg::KIND_REJECT;
		end else begin
			unique case (state_q)
				FE_IDLE: begin
					if (accept) begin
						step_q <= step_size;
						angle_q <= lower_limit;
						idx_q <= '0;
						n_q <= segment_count;
						if (bad) begin
							kind_q <= sasi_pkg::KIND_REJECT;
							state_q <= FE_ONE;
						end else if (segment_count == '0) begin
							kind_q <= sasi_pkg::KIND_EMPTY;
							state_q <= FE_ONE;
						end else begin
							state_q <= FE_GEN;
						end
					end
				end
				FE_GEN: begin
					if (push) begin
						angle_q <= angle_q + step_q;
						idx_q <= idx_q + 1'b1;
						if (is_last) begin
							state_q <= FE_IDLE;
						end
					end
				end
				FE_ONE: begin
					if (push) begin
						state_q <= FE_IDLE;
					end
				end
				default: state_q <= FE_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/sasi_queue.sv =====
`default_nettype none
module sasi_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  sasi_pkg::entry_t       push_entry,
	output logic                   full,
	output logic                   pop_valid,
	output sasi_pkg::entry_t       pop_entry
);

	localparam int unsigned PTR_W = $clog2(sasi_pkg::QUEUE_DEPTH);

	sasi_pkg::entry_t   mem_q [0:sasi_pkg::QUEUE_DEPTH-1];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;

	assign full = (count_q == (PTR_W+1)'(sasi_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push = push && !full;

	// Storage; the sine pipeline drains one beat every cycle while the queue is not empty
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_valid) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(pop_valid);
		end
	end

endmodule
`default_nettype wire

// ===== design/sasi_sine.sv =====
`default_nettype none
module sasi_sine #(
	parameter int unsigned SINE_ITERATIONS = sasi_pkg::SINE_ITER_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  sasi_pkg::entry_t                    in_entry,
	output logic                                out_valid,
	output sasi_pkg::tag_t                      out_tag,
	output logic [sasi_pkg::SAMPLE_W-1:0]       out_sample
);

	localparam int unsigned N = SINE_ITERATIONS;

	// Range reduction stages
	logic signed [31:0] a_s1, a_s2;
	logic signed [7:0]  q_s1;
	logic signed [58:0] qp_s2;
	logic signed [58:0] r_s3;
	logic [50:0]        r_s4;
	logic [3:0]         v_s;
	sasi_pkg::tag_t     t_s1, t_s2, t_s3, t_s4;

	logic signed [47:0] prod;
	logic signed [58:0] ash;
	logic signed [58:0] rp, rm;
	logic [50:0]        fold;

	// CORDIC stages, index 0 is the entry register
	logic signed [sasi_pkg::CORDIC_W-1:0] cx_s [0:N];
	logic signed [sasi_pkg::CORDIC_W-1:0] cy_s [0:N];
	logic signed [sasi_pkg::CORDIC_W-1:0] cz_s [0:N];
	sasi_pkg::tag_t                       ct_s [0:N];
	logic [N:0]                           cv_s;

	logic [sasi_pkg::CORDIC_W-1:0] y_abs;
	logic [sasi_pkg::CORDIC_W:0]   y_rnd;
	logic [28:0]                   y_q24;
	logic [sasi_pkg::SAMPLE_W-1:0] sample_q;
	sasi_pkg::tag_t                tag_q;

	assign prod = 48'($signed(in_entry.angle)) * 48'(sasi_pkg::RECIP_PI);
	assign ash  = {{3{a_s2[31]}}, a_s2, 24'd0};
	assign rp   = r_s3 + 59'(sasi_pkg::PI_Q48);
	assign rm   = r_s3 - 59'(sasi_pkg::PI_Q48);
	assign fold = (r_s4 > sasi_pkg::HALF_PI_Q48) ? (51'(sasi_pkg::PI_Q48) - r_s4) : r_s4;

	// Valid bits of the range reduction stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[2:0], in_valid};
		end
	end

	// Quotient estimate, remainder and fold into [0, pi/2]
	always_ff @(posedge clk) begin
		a_s1 <= $signed(in_entry.angle);
		q_s1 <= prod[47:40];
		t_s1 <= in_entry.tag;
		a_s2 <= a_s1;
		qp_s2 <= 59'(q_s1) * 59'(sasi_pkg::PI_Q48);
		t_s2 <= t_s1;
		r_s3 <= ash - qp_s2;
		t_s3 <= t_s2;
		if (r_s3 < 0) begin
			r_s4 <= rp[50:0];
		end else if (r_s3 >= 59'(sasi_pkg::PI_Q48)) begin
			r_s4 <= rm[50:0];
		end else begin
			r_s4 <= r_s3[50:0];
		end
		t_s4 <= t_s3;
		cx_s[0] <= sasi_pkg::GAIN_Q30;
		cy_s[0] <= '0;
		cz_s[0] <= $signed(sasi_pkg::CORDIC_W'(fold[50:18]));
		ct_s[0] <= t_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= v_s[3];
		end
	end

	// One rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [sasi_pkg::CORDIC_W-1:0] dx, dy, at;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign at = $signed(sasi_pkg::CORDIC_W'(sasi_pkg::atan_q30(i)));

		always_ff @(posedge clk) begin
			if (!cz_s[i][sasi_pkg::CORDIC_W-1]) begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				cz_s[i+1] <= cz_s[i] - at;
			end else begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				cz_s[i+1] <= cz_s[i] + at;
			end
			ct_s[i+1] <= ct_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end
	end

	// Rectify, round to Q.24 and cap at one
	assign y_abs = cy_s[N][sasi_pkg::CORDIC_W-1] ? 34'(-cy_s[N]) : 34'(cy_s[N]);
	assign y_rnd = 35'(y_abs) + 35'd32;
	assign y_q24 = y_rnd[34:6];

	always_ff @(posedge clk) begin
		if (y_q24 > 29'(sasi_pkg::ONE_Q24)) begin
			sample_q <= sasi_pkg::ONE_Q24;
		end else begin
			sample_q <= y_q24[24:0];
		end
		tag_q <= ct_s[N];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= cv_s[N];
		end
	end

	assign out_tag = tag_q;
	assign out_sample = sample_q;

endmodule
`default_nettype wire

// ===== design/sasi_back.sv =====
`default_nettype none
module sasi_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  sasi_pkg::tag_t                            in_tag,
	input  wire logic [sasi_pkg::SAMPLE_W-1:0]        in_sample,
	input  wire logic signed [sasi_pkg::ANGLE_W-1:0]  step,
	output logic                                      done,
	output logic [sasi_pkg::SUM_W-1:0]                weighted_sum,
	output logic [sasi_pkg::INTEG_W-1:0]              integral,
	output logic                                      status
);

	typedef enum logic [2:0] {BK_ACC, BK_MUL, BK_ADD, BK_DIV, BK_OUT} bk_state_t;

	// Reciprocal of three for an exact quotient of an 18-bit partial dividend
	localparam logic [19:0] RECIP3 = 20'd349526;

	bk_state_t                       state_q;
	logic [sasi_pkg::SUM_W-1:0]      sum_q;
	logic [45:0]                     phi_q;
	logic [55:0]                     plo_q;
	logic [sasi_pkg::PROD_W:0]       dvd_q;
	logic [1:0]                      rem_q;
	logic [1:0]                      cnt_q;
	logic                            done_q;
	logic [sasi_pkg::SUM_W-1:0]      wsum_q;
	logic [sasi_pkg::INTEG_W-1:0]    integ_q;
	logic                            status_q;

	logic [sasi_pkg::SUM_W-1:0]      wsample;
	logic [31:0]                     habs;
	logic [17:0]                     part;
	logic [37:0]                     pprod;
	logic [15:0]                     qdig;
	logic [1:0]                      rdig;
	logic [sasi_pkg::INTEG_W-1:0]    mag;

	// Scale the sample by its Simpson weight
	always_comb begin
		case (in_tag.weight)
			sasi_pkg::WT_FOUR: wsample = sasi_pkg::SUM_W'({in_sample, 2'b00});
			sasi_pkg::WT_TWO:  wsample = sasi_pkg::SUM_W'({in_sample, 1'b0});
			default:           wsample = sasi_pkg::SUM_W'(in_sample);
		endcase
	end

	assign habs = step[31] ? 32'(-step) : 32'(step);

	// One base 2^16 digit of the division by three: remainder and next 16 bits
	assign part  = {rem_q, dvd_q[sasi_pkg::PROD_W:sasi_pkg::PROD_W-15]};
	assign pprod = 38'(part) * 38'(RECIP3);
	assign qdig  = pprod[35:20];
	assign rdig  = 2'(part - 18'(qdig) * 18'd3);
	assign mag   = dvd_q[sasi_pkg::INTEG_W-1:0];

	// Accumulate, scale by the step, divide by three sixteen bits per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ACC;
			sum_q <= '0;
			done_q <= 1'b0;
			status_q <= 1'b0;
			wsum_q <= '0;
			integ_q <= '0;
			phi_q <= '0;
			plo_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				BK_ACC: begin
					if (in_valid) begin
						case (in_tag.kind)
							sasi_pkg::KIND_SAMPLE: begin
								sum_q <= sum_q + wsample;
								if (in_tag.last) begin
									state_q <= BK_MUL;
								end
							end
							sasi_pkg::KIND_REJECT: begin
								done_q <= 1'b1;
								status_q <= 1'b1;
								wsum_q <= '0;
								integ_q <= '0;
							end
							default: begin
								done_q <= 1'b1;
								status_q <= 1'b0;
								wsum_q <= '0;
								integ_q <= '0;
							end
						endcase
					end
				end
				BK_MUL: begin
					phi_q <= 46'(habs) * 46'(sum_q[sasi_pkg::SUM_W-1:sasi_pkg::FRAC_W]);
					plo_q <= 56'(habs) * 56'(sum_q[sasi_pkg::FRAC_W-1:0]);
					state_q <= BK_ADD;
				end
				BK_ADD: begin
					dvd_q <= (sasi_pkg::PROD_W+1)'(phi_q) +
						(sasi_pkg::PROD_W+1)'(plo_q[55:24]);
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= BK_DIV;
				end
				BK_DIV: begin
					dvd_q <= {dvd_q[sasi_pkg::PROD_W-16:0], qdig};
					rem_q <= rdig;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd2) begin
						state_q <= BK_OUT;
					end
				end
				BK_OUT: begin
					done_q <= 1'b1;
					status_q <= 1'b0;
					wsum_q <= sum_q;
					integ_q <= step[31] ? (sasi_pkg::INTEG_W'(0) - mag) : mag;
					sum_q <= '0;
					state_q <= BK_ACC;
				end
				default: state_q <= BK_ACC;
			endcase
		end
	end

	assign done = done_q;
	assign weighted_sum = wsum_q;
	assign integral = integ_q;
	assign status = status_q;

endmodule
`default_nettype wire

// ===== design/simpson_abs_sine_integrator_unit.sv =====
`default_nettype none
// Simpson one-third rule integrator of |sin(x)| in fixed point.
// Command channel: a request (lower_limit, step_size, segment_count) is taken
// at a clock edge where start is high and busy is low. busy then stays high
// until the result beat has been shown.
// Result channel: done is high for exactly one cycle, with weighted_sum,
// integral and status valid in that cycle. The receiver cannot stall it.
// An odd count or a count above MAX_SEGMENTS gives status 1 and zero results;
// a zero count gives zero results with status 0.
// A valid request of N segments runs as follows: the front issues one angle
// per cycle while the queue is not full (N + 1 beats), the pipelined sine
// unit (range reduction, then CORDIC rotations) turns them into samples,
// and the final division by three runs sixteen quotient bits per cycle.
// One request is in work at a time.
// Reset (arst_n low) clears all control state; no request is in work after it.
module simpson_abs_sine_integrator_unit #(
	parameter int unsigned MAX_SEGMENTS    = sasi_pkg::MAX_SEGMENTS_DEF,
	parameter int unsigned SINE_ITERATIONS = sasi_pkg::SINE_ITER_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [sasi_pkg::ANGLE_W-1:0]  lower_limit,
	input  wire logic signed [sasi_pkg::ANGLE_W-1:0]  step_size,
	input  wire logic        [sasi_pkg::COUNT_W-1:0]  segment_count,
	output logic                                      done,
	output logic [sasi_pkg::SUM_W-1:0]                weighted_sum,
	output logic signed [sasi_pkg::INTEG_W-1:0]       integral,
	output logic                                      status
);

	logic                                busy_q;
	logic                                accept;
	logic                                push;
	logic                                full;
	sasi_pkg::entry_t                    push_entry;
	logic                                pop_valid;
	sasi_pkg::entry_t                    pop_entry;
	logic signed [sasi_pkg::ANGLE_W-1:0] step;
	logic                                smp_valid;
	sasi_pkg::tag_t                      smp_tag;
	logic [sasi_pkg::SAMPLE_W-1:0]       smp_value;
	logic [sasi_pkg::INTEG_W-1:0]        integ_raw;

	assign accept = start && !busy_q;
	assign busy = busy_q;
	assign integral = $signed(integ_raw);

	// Busy from request beat to result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	sasi_front #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.lower_limit(lower_limit),
		.step_size(step_size),
		.segment_count(segment_count),
		.full(full),
		.push(push),
		.entry(push_entry),
		.step(step)
	);

	sasi_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.pop_valid(pop_valid),
		.pop_entry(pop_entry)
	);

	sasi_sine #(
		.SINE_ITERATIONS(SINE_ITERATIONS)
	) u_sine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pop_valid),
		.in_entry(pop_entry),
		.out_valid(smp_valid),
		.out_tag(smp_tag),
		.out_sample(smp_value)
	);

	sasi_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(smp_valid),
		.in_tag(smp_tag),
		.in_sample(smp_value),
		.step(step),
		.done(done),
		.weighted_sum(weighted_sum),
		.integral(integ_raw),
		.status(status)
	);

	// A result beat only ends a request in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("result beat without a request in work");

	// A taken request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after a request beat");

	// A rejected request carries zero results
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (weighted_sum == '0 && integral == '0))
		else $error("rejected request with nonzero results");

	// The queue never takes a beat while full
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue overrun");

endmodule
`default_nettype wire
